// ===== rtl/sdq_pkg.sv =====
package sdq_pkg;

    // sample and result formats
    localparam int unsigned SMP_W     = 32;
    localparam int unsigned FRAC_W    = 8;
    localparam int unsigned SUM_W     = SMP_W + 1;
    localparam int unsigned Q_W       = SUM_W - FRAC_W;
    localparam int unsigned OUT_W     = 24;
    localparam int unsigned NARROW_W  = 16;
    localparam int unsigned IDX_W     = 6;

    // noise generator
    localparam int unsigned SEED_W    = 31;
    localparam int unsigned DIGITS    = 16;
    localparam int unsigned DCNT_W    = 4;
    localparam logic [SEED_W-1:0] SEED_RESET = 31'h16BA2118;
    localparam logic [SEED_W-1:0] LCG_MUL    = 31'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD    = 31'd12345;
    localparam logic [SEED_W-1:0] LCG_MUL_X2 = {LCG_MUL[SEED_W-2:0], 1'b0};
    localparam logic [SEED_W-1:0] LCG_MUL_X3 = LCG_MUL_X2 + LCG_MUL;

    // configuration register indexes
    localparam logic CFG_WIDE_OUTPUT = 1'b0;
    localparam logic CFG_DITHER_ON   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NOISE,
        S_ROUND,
        S_DONE
    } t_sdq_state;

    typedef struct packed {
        logic             load_smp;
        logic             load_dth;
        logic             step;
        logic [IDX_W-1:0] idx;
    } t_lane_ctl;

endpackage

// ===== rtl/sdq_lcg.sv =====
module sdq_lcg
    import sdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_done,
    output logic [SEED_W-1:0] o_seed
);

    logic [SEED_W-1:0] r_seed;
    logic [SEED_W-1:0] r_acc;
    logic [SEED_W:0]   r_dig;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [SEED_W-1:0] w_prod;
    logic              w_last;
    logic [SEED_W-1:0] n_acc;

    // radix-4 horner step, seed digits enter msb first
    always_comb begin
        case (r_dig[SEED_W:SEED_W-1])
            2'd0:    w_prod = '0;
            2'd1:    w_prod = LCG_MUL;
            2'd2:    w_prod = LCG_MUL_X2;
            default: w_prod = LCG_MUL_X3;
        endcase
        w_last = (r_cnt == DCNT_W'(DIGITS - 1));
        n_acc  = {r_acc[SEED_W-3:0], 2'b00} + w_prod + (w_last ? LCG_ADD : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_seed <= n_acc;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_dig <= {1'b0, r_seed};
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_dig <= {r_dig[SEED_W-2:0], 2'b00};
        end
    end

    assign o_done = r_done;
    assign o_seed = r_seed;

endmodule

// ===== rtl/sdq_round.sv =====
module sdq_round
    import sdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctl         i_ctl,
    input  logic [SMP_W-1:0]  i_sample,
    input  logic [FRAC_W-1:0] i_dither,
    input  logic              i_wide,
    output logic [OUT_W-1:0]  o_result
);

    logic [SMP_W-1:0]  r_smp;
    logic [FRAC_W-1:0] r_dth;
    logic [FRAC_W-1:0] r_frac;
    logic [Q_W-1:0]    r_q;
    logic              r_c1;
    logic              r_c2;

    logic w_s;
    logic w_rup;
    logic w_qb;
    logic n_c1;
    logic n_c2;
    logic w_ovf;

    // one sum bit per step, lsb first; rounding carry starts at the first integer bit
    always_comb begin
        w_s   = r_smp[0] ^ r_dth[0] ^ r_c1;
        n_c1  = (r_smp[0] & r_dth[0]) | (r_c1 & (r_smp[0] ^ r_dth[0]));
        w_rup = (r_frac > 8'd128) || ((r_frac == 8'd128) && w_s);
        if (i_ctl.idx == IDX_W'(FRAC_W)) begin
            w_qb = w_s ^ w_rup;
            n_c2 = w_s & w_rup;
        end else begin
            w_qb = w_s ^ r_c2;
            n_c2 = w_s & r_c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= 1'b0;
            r_c2 <= 1'b0;
        end else if (i_ctl.load_smp) begin
            r_c1 <= 1'b0;
            r_c2 <= 1'b0;
        end else if (i_ctl.step) begin
            r_c1 <= n_c1;
            if (i_ctl.idx >= IDX_W'(FRAC_W)) begin
                r_c2 <= n_c2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_smp) begin
            r_smp <= i_sample;
        end else if (i_ctl.step) begin
            r_smp <= {r_smp[SMP_W-1], r_smp[SMP_W-1:1]};
        end
        if (i_ctl.load_dth) begin
            r_dth <= i_dither;
        end else if (i_ctl.step) begin
            r_dth <= {1'b0, r_dth[FRAC_W-1:1]};
        end
        if (i_ctl.step) begin
            if (i_ctl.idx < IDX_W'(FRAC_W)) begin
                r_frac <= {w_s, r_frac[FRAC_W-1:1]};
            end else begin
                r_q <= {w_qb, r_q[Q_W-1:1]};
            end
        end
    end

    // saturation of the rounded value
    always_comb begin
        if (i_wide) begin
            w_ovf = (r_q[Q_W-1] != r_q[OUT_W-1]);
        end else begin
            w_ovf = !((&r_q[Q_W-1:NARROW_W-1]) || !(|r_q[Q_W-1:NARROW_W-1]));
        end
        if (!w_ovf) begin
            o_result = r_q[OUT_W-1:0];
        end else if (i_wide) begin
            o_result = r_q[Q_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            o_result = r_q[Q_W-1]
                ? {{(OUT_W-NARROW_W+1){1'b1}}, {(NARROW_W-1){1'b0}}}
                : {{(OUT_W-NARROW_W+1){1'b0}}, {(NARROW_W-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/stereo_dither_quantizer.sv =====
// flow: with dither on, an input frame passes two generator advances (left, then right),
// 33 serial rounding steps and one output load; with dither off the advances are skipped
// pacing: a new frame is taken only in the idle state; the bit-serial adders and the
// radix-4 generator multiply set the pace, and the output register frees the input side
// unless a result still waits there when the next one is ready
// reset: synchronous active-low; seed returns to 0x16BA2118, wide_output 0, dither_on 1
module stereo_dither_quantizer
    import sdq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [2*SMP_W-1:0]   i_s_axis_tdata,   // left_sample, right_sample
    input  logic                 i_s_axis_tlast,   // block_end
    // output stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [2*OUT_W-1:0]   o_m_axis_tdata,   // left_out, right_out
    output logic                 o_m_axis_tlast,   // block_last
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic                 i_cfg_wdata
);

    t_sdq_state r_state;
    t_sdq_state n_state;

    logic [IDX_W-1:0]   r_cnt;
    logic               r_phase;     // 0 while drawing left noise, 1 for right
    logic               r_last;
    logic               r_wide;
    logic               r_dith;
    logic               r_ovalid;
    logic [2*OUT_W-1:0] r_odata;
    logic               r_olast;

    logic               w_in_acc;
    logic               w_lcg_start;
    logic               w_lcg_done;
    logic [SEED_W-1:0]  w_seed;
    logic [FRAC_W-1:0]  w_dither;
    logic               w_out_load;
    logic               w_round_end;
    t_lane_ctl          w_ctl_l;
    t_lane_ctl          w_ctl_r;
    logic [OUT_W-1:0]   w_res_l;
    logic [OUT_W-1:0]   w_res_r;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_round_end     = (r_cnt == IDX_W'(SUM_W - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_dith ? S_NOISE : S_ROUND;
                end
            end
            S_NOISE: begin
                if (w_lcg_done && r_phase) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (w_round_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_lcg_start      = 1'b0;
        w_out_load       = 1'b0;
        w_ctl_l          = '0;
        w_ctl_r          = '0;
        w_ctl_l.idx      = r_cnt;
        w_ctl_r.idx      = r_cnt;
        // noise is the top 8 bits of the fresh seed, zero when undithered
        w_dither         = (r_state == S_NOISE) ? w_seed[SEED_W-1:SEED_W-FRAC_W] : '0;
        case (r_state)
            S_IDLE: begin
                w_ctl_l.load_smp = w_in_acc;
                w_ctl_r.load_smp = w_in_acc;
                w_ctl_l.load_dth = w_in_acc & ~r_dith;
                w_ctl_r.load_dth = w_in_acc & ~r_dith;
                w_lcg_start      = w_in_acc & r_dith;
            end
            S_NOISE: begin
                w_ctl_l.load_dth = w_lcg_done & ~r_phase;
                w_ctl_r.load_dth = w_lcg_done & r_phase;
                w_lcg_start      = w_lcg_done & ~r_phase;
            end
            S_ROUND: begin
                w_ctl_l.step = 1'b1;
                w_ctl_r.step = 1'b1;
            end
            S_DONE: begin
                w_out_load = ~r_ovalid | i_m_axis_tready;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_phase  <= 1'b0;
            r_wide   <= 1'b0;
            r_dith   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == S_ROUND) ? r_cnt + 1'b1 : '0;
            if (r_state == S_IDLE) begin
                r_phase <= 1'b0;
            end else if (r_state == S_NOISE && w_lcg_done) begin
                r_phase <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDE_OUTPUT: r_wide <= i_cfg_wdata;
                    CFG_DITHER_ON:   r_dith <= i_cfg_wdata;
                    default:         r_wide <= r_wide;
                endcase
            end
            // output register: a new result may load while the old one leaves
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_last <= i_s_axis_tlast;
        end
        if (w_out_load) begin
            r_odata <= {w_res_r, w_res_l};
            r_olast <= r_last;
        end
    end

    sdq_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lcg_start),
        .o_done  (w_lcg_done),
        .o_seed  (w_seed)
    );

    sdq_round u_round_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_l),
        .i_sample (i_s_axis_tdata[SMP_W-1:0]),
        .i_dither (w_dither),
        .i_wide   (r_wide),
        .o_result (w_res_l)
    );

    sdq_round u_round_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_r),
        .i_sample (i_s_axis_tdata[2*SMP_W-1:SMP_W]),
        .i_dither (w_dither),
        .i_wide   (r_wide),
        .o_result (w_res_r)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

endmodule

// ===== sim/tb_stereo_dither_quantizer.sv =====
module tb_stereo_dither_quantizer
    import sdq_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_FRAMES = 1350;
    localparam int unsigned SETTLE_CYCLES = 100;

    // expected output frames, computed from the accepted input frames
    class quantized_frame_board;
        typedef struct packed {
            logic [OUT_W-1:0] left;
            logic [OUT_W-1:0] right;
            logic             last;
        } t_frame;

        t_frame          pending_frames[$];
        logic [SEED_W-1:0] seed;
        logic            wide;
        logic            dither;
        int unsigned     errors;

        function new();
            seed   = SEED_RESET;
            wide   = 1'b0;
            dither = 1'b1;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic val);
            if (idx == CFG_WIDE_OUTPUT)
                wide = val;
            else
                dither = val;
        endfunction

        // one generator step, the top 8 bits of the new seed are the dither
        function logic [7:0] advance_noise();
            logic [63:0] prod;
            prod = 64'(seed) * 64'(LCG_MUL) + 64'(LCG_ADD);
            seed = prod[SEED_W-1:0];
            return seed[SEED_W-1:SEED_W-8];
        endfunction

        // round half to even, then clamp to the selected width
        function logic [OUT_W-1:0] round_saturate(longint v);
            longint     q;
            longint     hi;
            longint     lo;
            logic [7:0] frac;
            frac = 8'(v & 255);
            q    = v >>> FRAC_W;
            if (frac > 8'h80 || (frac == 8'h80 && q[0]))
                q = q + 1;
            hi = wide ? 64'sd8388607 : 64'sd32767;
            lo = wide ? -64'sd8388608 : -64'sd32768;
            if (q > hi)
                q = hi;
            if (q < lo)
                q = lo;
            return q[OUT_W-1:0];
        endfunction

        function void note_frame(logic [SMP_W-1:0] l, logic [SMP_W-1:0] r, logic last);
            longint ls;
            longint rs;
            t_frame f;
            ls = $signed(l);
            rs = $signed(r);
            // left channel takes the first generator step
            if (dither) begin
                ls = ls + longint'(advance_noise());
                rs = rs + longint'(advance_noise());
            end
            f.left  = round_saturate(ls);
            f.right = round_saturate(rs);
            f.last  = last;
            pending_frames.push_back(f);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_frame(logic [2*OUT_W-1:0] data, logic last);
            t_frame f;
            if (pending_frames.size() == 0) begin
                flag($sformatf("unexpected output frame: left %h right %h last %b",
                               data[OUT_W-1:0], data[2*OUT_W-1:OUT_W], last));
                return;
            end
            f = pending_frames.pop_front();
            if (data[OUT_W-1:0] !== f.left)
                flag($sformatf("left mismatch: expected %h actual %h",
                               f.left, data[OUT_W-1:0]));
            if (data[2*OUT_W-1:OUT_W] !== f.right)
                flag($sformatf("right mismatch: expected %h actual %h",
                               f.right, data[2*OUT_W-1:OUT_W]));
            if (last !== f.last)
                flag($sformatf("tlast mismatch: expected %b actual %b", f.last, last));
        endfunction
    endclass

    // clock and synchronous active-low reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // block inputs, all known from time zero
    logic                 i_s_axis_tvalid = 1'b0;
    logic [2*SMP_W-1:0]   i_s_axis_tdata  = '0;
    logic                 i_s_axis_tlast  = 1'b0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic                 i_cfg_idx       = 1'b0;
    logic                 i_cfg_wdata     = 1'b0;

    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [2*OUT_W-1:0]   o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    stereo_dither_quantizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // left_sample, right_sample
        .i_s_axis_tlast  (i_s_axis_tlast),   // block_end
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // left_out, right_out
        .o_m_axis_tlast  (o_m_axis_tlast),   // block_last
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    quantized_frame_board board = new();

    // when low, neither side inserts gaps
    logic        idle_on = 1'b1;
    int unsigned sink_stall = 0;
    int unsigned cycles = 0;

    // gap length: mostly short, now and then long
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, 3);
        return $urandom_range(10, 40);
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // output side: check every accepted transaction, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_frame(o_m_axis_tdata, o_m_axis_tlast);
        if (sink_stall > 0) begin
            i_m_axis_tready <= 1'b0;
            sink_stall      <= sink_stall - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                sink_stall <= pick_gap();
        end
    end

    // present one frame and hold it until the block takes it;
    // called and returns at a rising edge
    task automatic send_frame(logic [SMP_W-1:0] l, logic [SMP_W-1:0] r, logic last);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, l};
        i_s_axis_tlast  <= last;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        board.note_frame(l, r, last);
    endtask

    // stop sending and wait for every expected frame to come out
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_frames.size() != 0)
            @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(logic idx, logic val);
        drain();
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        board.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // random sample, weighted toward range ends and rounding ties
    function automatic logic [SMP_W-1:0] pick_sample();
        logic [SMP_W-1:0] base;
        logic [7:0]       frac;
        logic             neg;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0, 5: return $urandom;
            // around the 16-bit limits
            1: base = $urandom_range(30767, 34767) * 256 + $urandom_range(0, 255);
            // around the 24-bit limits, up to the full 32-bit span
            2: base = $urandom_range(8388000, 8388607) * 256 + $urandom_range(0, 255);
            // halfway points and their neighbors
            3: begin
                case ($urandom_range(0, 4))
                    0: frac = 8'h80;
                    1: frac = 8'h7f;
                    2: frac = 8'h81;
                    3: frac = 8'h00;
                    default: frac = 8'hff;
                endcase
                base = $urandom_range(0, 4000) * 256 + frac;
            end
            default: base = $urandom_range(0, 1 << 20);
        endcase
        // bitwise inverse gives the mirrored negative value, -base - 1
        return neg ? ~base : base;
    endfunction

    initial begin
        int unsigned sent;
        int unsigned n;
        int unsigned phase;
        logic        wide;
        logic        dith;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, narrow with dither
        idle_on = 1'b0;
        send_frame(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_frame(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_frame(32'h007F_FF00, 32'hFF80_0000, 1'b0);

        // narrow, no dither: ties to even and the 16-bit limits
        write_reg(CFG_DITHER_ON, 1'b0);
        send_frame(32'h0000_0180, 32'h0000_0280, 1'b0);
        send_frame(32'hFFFF_FF80, 32'hFFFF_FE80, 1'b1);
        send_frame(32'h0000_007F, 32'h0000_0081, 1'b0);
        send_frame(32'h007F_FF80, 32'hFF7F_FF80, 1'b0);
        send_frame(32'h007F_FF7F, 32'hFF7F_FF00, 1'b1);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);

        // wide, no dither: the 24-bit limits
        write_reg(CFG_WIDE_OUTPUT, 1'b1);
        send_frame(32'h7FFF_FF80, 32'h8000_0080, 1'b0);
        send_frame(32'h7FFF_FF7F, 32'h8000_0000, 1'b1);
        send_frame(32'h0080_0000, 32'hFF7F_FFFF, 1'b0);
        send_frame(32'h0000_0180, 32'hFFFF_FE80, 1'b0);

        // wide with dither
        write_reg(CFG_DITHER_ON, 1'b1);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_frame(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_frame(32'h007F_FF80, 32'hFF80_0000, 1'b0);

        // random phases; the first four walk every setting
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_FRAMES) begin
            if (phase < 4) begin
                wide = phase[0];
                dith = phase[1];
            end else begin
                wide = 1'($urandom_range(0, 1));
                dith = 1'($urandom_range(0, 1));
            end
            write_reg(CFG_WIDE_OUTPUT, wide);
            write_reg(CFG_DITHER_ON, dith);
            idle_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(60, 200);
            if (n > RANDOM_FRAMES - sent)
                n = RANDOM_FRAMES - sent;
            repeat (n)
                send_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
            sent  += n;
            phase += 1;
        end

        // wait out the tail, any late frame counts as unexpected
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending_frames.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sdq_pkg.sv
rtl/sdq_lcg.sv
rtl/sdq_round.sv
rtl/stereo_dither_quantizer.sv
sim/tb_stereo_dither_quantizer.sv
